// ===== rtl/core/bblur_pkg.sv =====
// Types, constants and the reciprocal table shared by the box blur core.
package bblur_pkg;

   localparam int CHAN_W          = 8;
   localparam int IMAGE_WIDTH_W   = 11;
   localparam int IMAGE_HEIGHT_W  = 13;
   localparam int CSR_DATA_W      = 13;
   localparam int IMAGE_WIDTH_RST = 640;
   localparam int IMAGE_HEIGHT_RST = 480;
   localparam int SUM_W           = 12;
   localparam int NUM_W           = 13;
   localparam int COUNT_W         = 4;
   localparam int DIV_W           = 5;
   localparam int RECIP_W         = 16;
   localparam int RECIP_SHIFT     = 16;
   localparam int PROD_W          = NUM_W + RECIP_W;

   // channel 2 is red, 1 is green, 0 is blue
   typedef logic [2:0][CHAN_W-1:0] pixel_type;

   typedef enum logic [0:0] {
      CMD_PIXEL = 1'b0,
      CMD_FLUSH = 1'b1
   } cmd_type;

   typedef enum logic [0:0] {
      CSR_IMAGE_WIDTH  = 1'b0,
      CSR_IMAGE_HEIGHT = 1'b1
   } csr_index_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_UPDATE,
      S_MUL,
      S_FIX
   } state_type;

   // floor(2^16 / (2 * count)) for every neighbour count that can occur
   function automatic logic [RECIP_W-1:0] recip(input logic [COUNT_W-1:0] count);
      logic [RECIP_W-1:0] m;
      case (count)
         4'd1: m = 16'd32768;
         4'd2: m = 16'd16384;
         4'd3: m = 16'd10922;
         4'd4: m = 16'd8192;
         4'd6: m = 16'd5461;
         4'd9: m = 16'd3640;
         default: m = 16'd32768;
      endcase
      return m;
   endfunction

endpackage

// ===== rtl/core/box_blur_3x3_edge_clipped_core.sv =====
// Streaming 3x3 box blur with edge clipping, built around two line memories.
//
//   channel | direction | handshake          | payload
//   --------+-----------+--------------------+---------------------------------------
//   req     | in        | req_valid/req_stall | req_cmd, req_in_red/green/blue
//   rsp     | out       | rsp_valid/rsp_stall | rsp_out_red/green/blue, rsp_frame_last
//   csr     | in        | csr_valid/csr_ready | csr_index, csr_data
//
// An item that yields a result goes through accept (line memory read), update
// (memory write-back, window shift, masked sums), reciprocal multiply and remainder
// correction. An item without a result ends after the update; an early flush is dropped at accept.
// Reset clears positions and sets the frame to 640x480; line memories are not cleared.
// A result waits in the output register while rsp_stall is high; the next item is
// still accepted, and only the correction step waits for the register to free up.
module box_blur_3x3_edge_clipped_core #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 4096
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_valid,
   output logic                                   req_stall,
   input  bblur_pkg::cmd_type                     req_cmd,
   input  logic [bblur_pkg::CHAN_W-1:0]           req_in_red,
   input  logic [bblur_pkg::CHAN_W-1:0]           req_in_green,
   input  logic [bblur_pkg::CHAN_W-1:0]           req_in_blue,
   output logic                                   rsp_valid,
   input  logic                                   rsp_stall,
   output logic [bblur_pkg::CHAN_W-1:0]           rsp_out_red,
   output logic [bblur_pkg::CHAN_W-1:0]           rsp_out_green,
   output logic [bblur_pkg::CHAN_W-1:0]           rsp_out_blue,
   output logic                                   rsp_frame_last,
   input  logic                                   csr_valid,
   output logic                                   csr_ready,
   input  bblur_pkg::csr_index_type               csr_index,
   input  logic [bblur_pkg::CSR_DATA_W-1:0]       csr_data
);
   import bblur_pkg::*;

   localparam int COL_W = $clog2(MAX_WIDTH);
   localparam int CNT_W = $clog2(MAX_WIDTH + 1);
   localparam int ROW_W = $clog2(MAX_HEIGHT + 2);
   localparam int ROWX_W = ROW_W + 1;

   state_type                  state_ff, state_in;
   logic [IMAGE_WIDTH_W-1:0]   image_width_ff, image_width_in;
   logic [IMAGE_HEIGHT_W-1:0]  image_height_ff, image_height_in;
   logic [COL_W-1:0]           in_col_ff, in_col_in;
   logic [ROW_W-1:0]           in_row_ff, in_row_in;
   pixel_type                  px_ff, px_in;
   pixel_type                  up_rd_ff, mid_rd_ff;
   pixel_type                  win1_ff [3];
   pixel_type                  win1_in [3];
   pixel_type                  win2_ff [3];
   pixel_type                  win2_in [3];
   logic [SUM_W-1:0]           sum_ff [3];
   logic [SUM_W-1:0]           sum_in [3];
   logic [COUNT_W-1:0]         count_ff, count_in;
   logic                       last_ff, last_in;
   logic [NUM_W-1:0]           num_ff [3];
   logic [NUM_W-1:0]           num_in [3];
   logic [CHAN_W-1:0]          quo_ff [3];
   logic [CHAN_W-1:0]          quo_in [3];
   logic                       rsp_valid_ff, rsp_valid_in;
   pixel_type                  rsp_pix_ff, rsp_pix_in;
   logic                       rsp_last_ff, rsp_last_in;

   pixel_type                  upper_mem [MAX_WIDTH];
   pixel_type                  middle_mem [MAX_WIDTH];
   logic                       mem_re, mem_we;

   logic [CNT_W-1:0]           eff_w;
   logic [ROW_W-1:0]           eff_h;
   logic [ROWX_W-1:0]          row_x, h_x, orow_x;
   logic                       accept, row_live, drop_item, col_wrap;
   logic                       emit_edge, emit_mid, frame_end;
   logic                       top_ok, bot_ok, left_ok;
   logic [1:0]                 n_rows, n_cols;
   logic [2:0]                 row_mask, col_mask;
   pixel_type                  new_col [3];
   logic [DIV_W-1:0]           div;
   logic [PROD_W-1:0]          prod [3];
   logic [NUM_W-1:0]           rem [3];
   pixel_type                  fixed_pix;

   // clamp the programmed frame size to 1..MAX_WIDTH by 1..MAX_HEIGHT
   always_comb begin
      if (image_width_ff == '0) begin
         eff_w = CNT_W'(1);
      end else if (int'(image_width_ff) > MAX_WIDTH) begin
         eff_w = CNT_W'(MAX_WIDTH);
      end else begin
         eff_w = CNT_W'(image_width_ff);
      end
      if (image_height_ff == '0) begin
         eff_h = ROW_W'(1);
      end else if (int'(image_height_ff) > MAX_HEIGHT) begin
         eff_h = ROW_W'(MAX_HEIGHT);
      end else begin
         eff_h = ROW_W'(image_height_ff);
      end
   end

   assign accept    = req_valid && !req_stall;
   assign row_x     = ROWX_W'(in_row_ff);
   assign h_x       = ROWX_W'(eff_h);
   assign row_live  = row_x < h_x;
   assign drop_item = (req_cmd == CMD_FLUSH) && row_live;
   assign col_wrap  = (CNT_W'(in_col_ff) + CNT_W'(1)) >= eff_w;

   // last column of the row two above comes out on the first column of a row
   assign emit_edge = (in_col_ff == '0) && (row_x >= ROWX_W'(2)) &&
                      (row_x < h_x + ROWX_W'(2));
   assign emit_mid  = (in_col_ff != '0) && (row_x >= ROWX_W'(1)) &&
                      (row_x < h_x + ROWX_W'(1));
   assign orow_x    = emit_edge ? row_x - ROWX_W'(2) : row_x - ROWX_W'(1);
   assign frame_end = emit_edge && (row_x == h_x + ROWX_W'(1));
   assign top_ok    = orow_x >= ROWX_W'(1);
   assign bot_ok    = (orow_x + ROWX_W'(1)) < h_x;
   assign left_ok   = emit_edge ? (eff_w >= CNT_W'(2)) : (CNT_W'(in_col_ff) >= CNT_W'(2));
   assign row_mask  = {bot_ok, 1'b1, top_ok};
   assign col_mask  = {emit_mid, 1'b1, left_ok};
   assign n_rows    = 2'd1 + 2'(top_ok) + 2'(bot_ok);
   assign n_cols    = 2'd1 + 2'(left_ok) + 2'(emit_mid);

   assign new_col[0] = up_rd_ff;
   assign new_col[1] = mid_rd_ff;
   assign new_col[2] = px_ff;

   // masked neighbourhood sums: left = window col 1, center = col 2, right = new column
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         sum_in[ch] = '0;
         for (int r = 0; r < 3; r++) begin
            if (row_mask[r]) begin
               if (col_mask[0]) begin
                  sum_in[ch] = sum_in[ch] + SUM_W'(win1_ff[r][ch]);
               end
               sum_in[ch] = sum_in[ch] + SUM_W'(win2_ff[r][ch]);
               if (col_mask[2]) begin
                  sum_in[ch] = sum_in[ch] + SUM_W'(new_col[r][ch]);
               end
            end
         end
      end
   end

   // quotient estimate is exact or one low; one compare fixes it
   assign div = {count_ff, 1'b0};
   always_comb begin
      for (int ch = 0; ch < 3; ch++) begin
         num_in[ch] = NUM_W'({sum_ff[ch], 1'b0}) + NUM_W'(count_ff);
         prod[ch]   = PROD_W'(num_in[ch]) * PROD_W'(recip(count_ff));
         quo_in[ch] = prod[ch][RECIP_SHIFT +: CHAN_W];
         rem[ch]    = num_ff[ch] - NUM_W'(quo_ff[ch]) * NUM_W'(div);
         fixed_pix[ch] = quo_ff[ch] + CHAN_W'(rem[ch] >= NUM_W'(div));
      end
   end

   always_comb begin
      state_in        = state_ff;
      image_width_in  = image_width_ff;
      image_height_in = image_height_ff;
      in_col_in       = in_col_ff;
      in_row_in       = in_row_ff;
      px_in           = px_ff;
      win1_in         = win1_ff;
      win2_in         = win2_ff;
      count_in        = count_ff;
      last_in         = last_ff;
      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      rsp_pix_in      = rsp_pix_ff;
      rsp_last_in     = rsp_last_ff;
      mem_re          = 1'b0;
      mem_we          = 1'b0;
      case (state_ff)
         S_IDLE: begin
            // drop an early flush; start a read for everything else
            if (accept && !drop_item) begin
               mem_re = 1'b1;
               if (req_cmd == CMD_PIXEL && row_live) begin
                  px_in = {req_in_red, req_in_green, req_in_blue};
               end else begin
                  px_in = '0;
               end
               state_in = S_UPDATE;
            end
         end
         S_UPDATE: begin
            mem_we = 1'b1;
            for (int r = 0; r < 3; r++) begin
               win1_in[r] = win2_ff[r];
               win2_in[r] = new_col[r];
            end
            count_in = COUNT_W'(n_rows) * COUNT_W'(n_cols);
            last_in  = frame_end;
            if (col_wrap) begin
               in_col_in = '0;
               in_row_in = in_row_ff + ROW_W'(1);
            end else begin
               in_col_in = in_col_ff + COL_W'(1);
            end
            if (frame_end) begin
               in_col_in = '0;
               in_row_in = '0;
            end
            state_in = (emit_edge || emit_mid) ? S_MUL : S_IDLE;
         end
         S_MUL: begin
            state_in = S_FIX;
         end
         S_FIX: begin
            // hold until the output register is free
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_pix_in   = fixed_pix;
               rsp_last_in  = last_ff;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
      if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_IMAGE_WIDTH:  image_width_in  = csr_data[IMAGE_WIDTH_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_in = csr_data[IMAGE_HEIGHT_W-1:0];
            default: begin
            end
         endcase
         in_col_in = '0;
         in_row_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         image_width_ff  <= IMAGE_WIDTH_W'(IMAGE_WIDTH_RST);
         image_height_ff <= IMAGE_HEIGHT_W'(IMAGE_HEIGHT_RST);
         in_col_ff       <= '0;
         in_row_ff       <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         image_width_ff  <= image_width_in;
         image_height_ff <= image_height_in;
         in_col_ff       <= in_col_in;
         in_row_ff       <= in_row_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      win1_ff     <= win1_in;
      win2_ff     <= win2_in;
      count_ff    <= count_in;
      last_ff     <= last_in;
      rsp_pix_ff  <= rsp_pix_in;
      rsp_last_ff <= rsp_last_in;
      if (state_ff == S_UPDATE) begin
         sum_ff <= sum_in;
      end
      if (state_ff == S_MUL) begin
         num_ff <= num_in;
         quo_ff <= quo_in;
      end
   end

   // line memories: read at accept, write back during the update step at the same column
   always_ff @(posedge clock) begin
      if (mem_re) begin
         up_rd_ff  <= upper_mem[in_col_ff];
         mid_rd_ff <= middle_mem[in_col_ff];
      end
      if (mem_we) begin
         upper_mem[in_col_ff]  <= mid_rd_ff;
         middle_mem[in_col_ff] <= px_ff;
      end
   end

   // hold items while busy or while a register write is offered
   assign req_stall      = (state_ff != S_IDLE) || csr_valid;
   assign csr_ready      = (state_ff == S_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_out_red    = rsp_pix_ff[2];
   assign rsp_out_green  = rsp_pix_ff[1];
   assign rsp_out_blue   = rsp_pix_ff[0];
   assign rsp_frame_last = rsp_last_ff;

   a_col_in_frame: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(in_col_ff) < eff_w)
      else $error("input column beyond frame width");

   a_row_in_frame: assert property (@(posedge clock) disable iff (reset)
      row_x <= h_x + ROWX_W'(1))
      else $error("input row beyond drain limit");

   a_sum_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_MUL |->
         (int'(sum_ff[0]) <= 255 * int'(count_ff)) &&
         (int'(sum_ff[1]) <= 255 * int'(count_ff)) &&
         (int'(sum_ff[2]) <= 255 * int'(count_ff)))
      else $error("neighbourhood sum exceeds count");

   a_rem_bound: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FIX |->
         (int'(rem[0]) < 2 * int'(div)) &&
         (int'(rem[1]) < 2 * int'(div)) &&
         (int'(rem[2]) < 2 * int'(div)))
      else $error("reciprocal estimate off by more than one");

endmodule
